FILE: rtl/core/lfu_cache_table_assert.svh
// Assertion macros shared by the cache table RTL.
// Each macro expects clk and arst_n in scope.
`ifndef LFU_CACHE_TABLE_ASSERT_SVH
`define LFU_CACHE_TABLE_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define LFU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset
`define LFU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/lfu_pkg.sv
package lfu_pkg;

	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int STAMP_W = 48;
	localparam int CAP_W   = 5;

	// request kinds
	typedef enum logic {
		REQ_GET = 1'b0,
		REQ_PUT = 1'b1
	} req_t;

	// control from the scan sequencer to the selector
	typedef struct packed {
		logic clear;
		logic valid;
	} scan_ctl_t;

endpackage

FILE: rtl/core/lfu_victim_sel.sv
module lfu_victim_sel #(
	parameter int IDX_W      = 4,
	parameter int COUNT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lfu_pkg::scan_ctl_t            ctl,
	input  logic [lfu_pkg::KEY_W-1:0]     req_key,
	input  logic [IDX_W-1:0]              idx,
	input  logic [lfu_pkg::KEY_W-1:0]     ent_key,
	input  logic [lfu_pkg::VAL_W-1:0]     ent_value,
	input  logic [COUNT_BITS-1:0]         ent_count,
	input  logic [lfu_pkg::STAMP_W-1:0]   ent_stamp,
	output logic                          found,
	output logic [IDX_W-1:0]              match_idx,
	output logic [lfu_pkg::VAL_W-1:0]     match_value,
	output logic [COUNT_BITS-1:0]         match_count,
	output logic [IDX_W-1:0]              victim_idx,
	output logic [lfu_pkg::KEY_W-1:0]     victim_key
);
	import lfu_pkg::*;

	logic                 found_q;
	logic                 have_q;
	logic [IDX_W-1:0]     match_idx_q;
	logic [VAL_W-1:0]     match_value_q;
	logic [COUNT_BITS-1:0] match_count_q;
	logic [IDX_W-1:0]     victim_idx_q;
	logic [KEY_W-1:0]     victim_key_q;
	logic [COUNT_BITS-1:0] best_count_q;
	logic [STAMP_W-1:0]   best_stamp_q;
	logic                 key_match;
	logic                 take_victim;

	// first key match wins; lowest count, then oldest stamp, first slot on a full tie
	assign key_match   = !found_q && (ent_key == req_key);
	assign take_victim = !have_q || (ent_count < best_count_q) ||
		((ent_count == best_count_q) && (ent_stamp < best_stamp_q));

	// track whether a match and a victim have been seen
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			have_q  <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
			have_q  <= 1'b0;
		end else if (ctl.valid) begin
			if (key_match)
				found_q <= 1'b1;
			if (take_victim)
				have_q <= 1'b1;
		end
	end

	// hold the matching entry and the best victim so far
	always_ff @(posedge clk) begin
		if (ctl.valid) begin
			if (key_match) begin
				match_idx_q   <= idx;
				match_value_q <= ent_value;
				match_count_q <= ent_count;
			end
			if (take_victim) begin
				victim_idx_q <= idx;
				victim_key_q <= ent_key;
				best_count_q <= ent_count;
				best_stamp_q <= ent_stamp;
			end
		end
	end

	assign found       = found_q;
	assign match_idx   = match_idx_q;
	assign match_value = match_value_q;
	assign match_count = match_count_q;
	assign victim_idx  = victim_idx_q;
	assign victim_key  = victim_key_q;

endmodule

FILE: rtl/core/lfu_cache_table.sv
// Key/value cache with least-frequently-used replacement, least recent use
// breaking ties. Pulse start while busy is low to issue a get or a put; the
// result appears on done for exactly one cycle and cannot be held off, so the
// receiver must take it when it comes. Entries sit in a table memory with
// one read and one write port, scanned one slot per cycle over the occupied
// slots only; no new item is taken until the scan and write-back are through,
// and done pulses in the cycle after the write-back. A put while the clamped
// capacity is zero answers in the next cycle and leaves busy low. Capacity is
// written through cfg_valid/cfg_data, always ready; the user must write it
// only while the block is idle, and the block itself does not enforce this.
`include "lfu_cache_table_assert.svh"

module lfu_cache_table #(
	parameter int ENTRIES    = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              req_type,
	input  logic signed [lfu_pkg::KEY_W-1:0]  lookup_key,
	input  logic signed [lfu_pkg::VAL_W-1:0]  store_value,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lfu_pkg::CAP_W-1:0]         cfg_data,
	output logic                              done,
	output logic                              hit,
	output logic signed [lfu_pkg::VAL_W-1:0]  read_value,
	output logic                              evicted,
	output logic signed [lfu_pkg::KEY_W-1:0]  evicted_key
);
	import lfu_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef struct packed {
		logic [KEY_W-1:0]      key;
		logic [VAL_W-1:0]      value;
		logic [COUNT_BITS-1:0] count;
		logic [STAMP_W-1:0]    stamp;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_WRITE = 3'b100
	} state_t;

	state_t              state_q;
	logic [CAP_W-1:0]    capacity_q;
	logic [CAP_W-1:0]    occ_q;
	logic [CAP_W-1:0]    ptr_q;
	logic [STAMP_W-1:0]  use_clock_q;
	logic                req_put_q;
	logic [KEY_W-1:0]    req_key_q;
	logic [VAL_W-1:0]    req_val_q;

	entry_t              entry_mem [ENTRIES];
	entry_t              rd_entry_s1;
	logic [IDX_W-1:0]    rd_idx_s1;
	logic                rd_vld_s1;

	logic [CAP_W-1:0]    cap_eff;
	logic                accept;
	logic                cap_zero_put;
	logic                issue;
	scan_ctl_t           scan_ctl;

	logic                found;
	logic [IDX_W-1:0]    match_idx;
	logic [VAL_W-1:0]    match_value;
	logic [COUNT_BITS-1:0] match_count;
	logic [IDX_W-1:0]    victim_idx;
	logic [KEY_W-1:0]    victim_key;

	logic                mem_we;
	logic [IDX_W-1:0]    wr_idx;
	entry_t              wr_entry;
	logic                ins_new;
	logic                res_hit;
	logic [VAL_W-1:0]    res_val;
	logic                res_ev;
	logic [KEY_W-1:0]    res_evkey;

	logic                done_q;
	logic                hit_q;
	logic [VAL_W-1:0]    read_value_q;
	logic                evicted_q;
	logic [KEY_W-1:0]    evicted_key_q;

	// clamp capacity to the table depth
	assign cap_eff      = (32'(capacity_q) > ENTRIES) ? CAP_W'(ENTRIES) : capacity_q;
	assign busy         = (state_q != ST_IDLE);
	assign accept       = start && !busy;
	assign cap_zero_put = accept && (req_type == REQ_PUT) && (cap_eff == '0);
	assign cfg_ready    = 1'b1;

	// slots fill from the bottom and never free, so only 0 .. occ-1 are read
	assign issue          = (state_q == ST_SCAN) && (ptr_q < occ_q);
	assign scan_ctl.clear = accept;
	assign scan_ctl.valid = rd_vld_s1;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			capacity_q <= CAP_W'(16);
		else if (cfg_valid && cfg_ready)
			capacity_q <= cfg_data;
	end

	// sequencer, occupancy and use clock
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ptr_q       <= '0;
			occ_q       <= '0;
			use_clock_q <= '0;
			rd_vld_s1   <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && !cap_zero_put) begin
						state_q <= ST_SCAN;
						ptr_q   <= '0;
					end
				end
				ST_SCAN: begin
					if (issue)
						ptr_q <= ptr_q + 1'b1;
					else
						state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					state_q <= ST_IDLE;
					if (ins_new)
						occ_q <= occ_q + 1'b1;
					if (mem_we)
						use_clock_q <= use_clock_q + 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// capture the request
	always_ff @(posedge clk) begin
		if (accept) begin
			req_put_q <= (req_type == REQ_PUT);
			req_key_q <= lookup_key;
			req_val_q <= store_value;
		end
	end

	// entry table: one read and one write port, registered read
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_entry_s1 <= entry_mem[IDX_W'(ptr_q)];
			rd_idx_s1   <= IDX_W'(ptr_q);
		end
		if (mem_we)
			entry_mem[wr_idx] <= wr_entry;
	end

	lfu_victim_sel #(
		.IDX_W      (IDX_W),
		.COUNT_BITS (COUNT_BITS)
	) u_sel (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (scan_ctl),
		.req_key     (req_key_q),
		.idx         (rd_idx_s1),
		.ent_key     (rd_entry_s1.key),
		.ent_value   (rd_entry_s1.value),
		.ent_count   (rd_entry_s1.count),
		.ent_stamp   (rd_entry_s1.stamp),
		.found       (found),
		.match_idx   (match_idx),
		.match_value (match_value),
		.match_count (match_count),
		.victim_idx  (victim_idx),
		.victim_key  (victim_key)
	);

	// write-back: touch a hit, insert or replace on a put miss
	always_comb begin
		mem_we         = 1'b0;
		wr_idx         = match_idx;
		wr_entry.key   = req_key_q;
		wr_entry.value = req_val_q;
		wr_entry.count = COUNT_BITS'(1);
		wr_entry.stamp = use_clock_q;
		ins_new        = 1'b0;
		res_hit        = 1'b0;
		res_val        = '0;
		res_ev         = 1'b0;
		res_evkey      = '0;
		if (state_q == ST_WRITE) begin
			if (found) begin
				mem_we         = 1'b1;
				res_hit        = 1'b1;
				wr_entry.count = (match_count == '1) ? match_count : match_count + 1'b1;
				if (!req_put_q) begin
					wr_entry.value = match_value;
					res_val        = match_value;
				end
			end else if (req_put_q) begin
				mem_we = 1'b1;
				if (occ_q < cap_eff) begin
					wr_idx  = IDX_W'(occ_q);
					ins_new = 1'b1;
				end else begin
					wr_idx    = victim_idx;
					res_ev    = 1'b1;
					res_evkey = victim_key;
				end
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= (state_q == ST_WRITE) || cap_zero_put;
	end

	// result payload
	always_ff @(posedge clk) begin
		if ((state_q == ST_WRITE) || cap_zero_put) begin
			hit_q         <= res_hit;
			read_value_q  <= res_val;
			evicted_q     <= res_ev;
			evicted_key_q <= res_evkey;
		end
	end

	assign done        = done_q;
	assign hit         = hit_q;
	assign read_value  = read_value_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;

	`LFU_ASSERT_NOW(a_occ_in_range, 1'b1, 32'(occ_q) <= ENTRIES, "occupancy beyond table depth")
	`LFU_ASSERT_NOW(a_scan_ptr, state_q == ST_SCAN, ptr_q <= occ_q, "scan pointer past occupancy")
	`LFU_ASSERT_NOW(a_evict_not_hit, done_q && evicted_q, !hit_q, "eviction reported on a hit")
	`LFU_ASSERT_NOW(a_evict_keeps_occ, done_q && evicted_q, $stable(occ_q), "eviction changed occupancy")
	`LFU_ASSERT_NEXT(a_write_done, state_q == ST_WRITE, done_q && !busy, "write-back gave no result")

endmodule
